### rtl/q4mv_pkg.sv
`default_nettype none

package q4mv_pkg;

  localparam int unsigned ACT_WIDTH_DEF   = 16;
  localparam int unsigned ACC_WIDTH_DEF   = 48;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned WEIGHT_W = NIB_W + 1;
  // weight times scale stays within +-8 * 65535, which fits 20 signed bits
  localparam int unsigned WS_W     = 20;

  localparam logic [NIB_W-1:0]           NIB_MASK = 4'hF;
  localparam logic signed [WEIGHT_W-1:0] NIB_BIAS = 5'sd8;

  typedef struct packed {
    logic signed [WS_W-1:0] ws_odd;
    logic signed [WS_W-1:0] ws_even;
    logic                   last;
  } wscale_t;

  // signed weight code minus bias, times the unsigned block scale
  function automatic logic signed [WS_W-1:0] weight_scale(
    input logic [NIB_W-1:0]   code,
    input logic [SCALE_W-1:0] scale
  );
    logic signed [WEIGHT_W-1:0]         w;
    logic signed [SCALE_W:0]            s;
    logic signed [WEIGHT_W+SCALE_W-1:0] p;
    w = $signed({1'b0, code & NIB_MASK}) - NIB_BIAS;
    s = $signed({1'b0, scale});
    p = (WEIGHT_W + SCALE_W)'(w) * (WEIGHT_W + SCALE_W)'(s);
    return p[WS_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/q4mv_in_if.sv
`default_nettype none

interface q4mv_in_if
  import q4mv_pkg::*;
#(
  parameter int unsigned ACT_WIDTH = ACT_WIDTH_DEF
) ();

  logic                        valid;
  logic                        ready;
  logic [BYTE_W-1:0]           weight_byte;
  logic [SCALE_W-1:0]          block_scale;
  logic signed [ACT_WIDTH-1:0] act_even;
  logic signed [ACT_WIDTH-1:0] act_odd;
  logic                        end_of_row;

  modport source (
    output valid, weight_byte, block_scale, act_even, act_odd, end_of_row,
    input  ready
  );

  modport sink (
    input  valid, weight_byte, block_scale, act_even, act_odd, end_of_row,
    output ready
  );

endinterface

`default_nettype wire

### rtl/q4mv_out_if.sv
`default_nettype none

interface q4mv_out_if
  import q4mv_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) ();

  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] row_sum;

  modport source (
    output valid, row_sum,
    input  ready
  );

  modport sink (
    input  valid, row_sum,
    output ready
  );

endinterface

`default_nettype wire

### rtl/q4mv_front.sv
`default_nettype none

module q4mv_front
  import q4mv_pkg::*;
#(
  parameter int unsigned ACT_WIDTH = ACT_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output      logic                        ready_o,
  input  wire logic [BYTE_W-1:0]           weight_byte_i,
  input  wire logic [SCALE_W-1:0]          block_scale_i,
  input  wire logic signed [ACT_WIDTH-1:0] act_even_i,
  input  wire logic signed [ACT_WIDTH-1:0] act_odd_i,
  input  wire logic                        end_of_row_i,
  output      logic                        valid_o,
  input  wire logic                        ready_i,
  output      wscale_t                     ws_o,
  output      logic signed [ACT_WIDTH-1:0] act_even_o,
  output      logic signed [ACT_WIDTH-1:0] act_odd_o
);

  logic                        v_q;
  wscale_t                     ws_q, ws_d;
  logic signed [ACT_WIDTH-1:0] ae_q, ao_q;

  assign ready_o = !v_q || ready_i;

  // split the byte into its two weights and fold in the block scale
  always_comb begin
    ws_d.ws_even = weight_scale(weight_byte_i[NIB_W-1:0], block_scale_i);
    ws_d.ws_odd  = weight_scale(weight_byte_i[BYTE_W-1:NIB_W], block_scale_i);
    ws_d.last    = end_of_row_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      ws_q <= ws_d;
      ae_q <= act_even_i;
      ao_q <= act_odd_i;
    end
  end

  assign valid_o    = v_q;
  assign ws_o       = ws_q;
  assign act_even_o = ae_q;
  assign act_odd_o  = ao_q;

endmodule

`default_nettype wire

### rtl/q4mv_fifo.sv
`default_nettype none

module q4mv_fifo
  import q4mv_pkg::*;
#(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  output      logic             ready_o,
  input  wire logic [WIDTH-1:0] data_i,
  output      logic             valid_o,
  input  wire logic             ready_i,
  output      logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign ready_o = (count_q != CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue fill count above depth");

  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q == rd_ptr_q) == (count_q == '0 || count_q == CNT_W'(DEPTH)))
    else $error("queue pointers disagree with fill count");
`endif

endmodule

`default_nettype wire

### rtl/q4mv_back.sv
`default_nettype none

module q4mv_back
  import q4mv_pkg::*;
#(
  parameter int unsigned ACT_WIDTH = ACT_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  output      logic                        ready_o,
  input  wire wscale_t                     ws_i,
  input  wire logic signed [ACT_WIDTH-1:0] act_even_i,
  input  wire logic signed [ACT_WIDTH-1:0] act_odd_i,
  output      logic                        valid_o,
  input  wire logic                        ready_i,
  output      logic signed [ACC_WIDTH-1:0] row_sum_o
);

  localparam int unsigned PROD_W = WS_W + ACT_WIDTH;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = ((ACC_WIDTH > PAIR_W) ? ACC_WIDTH : PAIR_W) + 1;
  localparam int unsigned TOP_W  = SUM_W - ACC_WIDTH + 1;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic                        s1_v_q;
  logic                        last_q;
  logic signed [PROD_W-1:0]    pe_q, po_q;
  logic signed [PROD_W-1:0]    pe_d, po_d;
  logic signed [ACC_WIDTH-1:0] acc_q;
  logic signed [ACC_WIDTH-1:0] sat_d;
  logic signed [SUM_W-1:0]     sum;
  logic [TOP_W-1:0]            sum_top;
  logic                        out_v_q;
  logic signed [ACC_WIDTH-1:0] row_sum_q;
  logic                        consume;

  // a row end needs a free output register, other items never wait
  assign consume = s1_v_q && (!last_q || !out_v_q || ready_i);
  assign ready_o = !s1_v_q || consume;

  assign pe_d = PROD_W'($signed(ws_i.ws_even)) * PROD_W'(act_even_i);
  assign po_d = PROD_W'($signed(ws_i.ws_odd)) * PROD_W'(act_odd_i);

  // exact three-term sum, then clamp to the accumulator range
  always_comb begin
    sum     = SUM_W'(acc_q) + SUM_W'(pe_q) + SUM_W'(po_q);
    sum_top = sum[SUM_W-1:ACC_WIDTH-1];
    if (sum_top == '0 || sum_top == '1) begin
      sat_d = sum[ACC_WIDTH-1:0];
    end else if (sum[SUM_W-1]) begin
      sat_d = ACC_MIN;
    end else begin
      sat_d = ACC_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      acc_q   <= '0;
    end else begin
      if (ready_o) begin
        s1_v_q <= valid_i;
      end
      if (consume) begin
        acc_q <= last_q ? '0 : sat_d;
      end
      if (consume && last_q) begin
        out_v_q <= 1'b1;
      end else if (ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      pe_q   <= pe_d;
      po_q   <= po_d;
      last_q <= ws_i.last;
    end
    if (consume && last_q) begin
      row_sum_q <= sat_d;
    end
  end

  assign valid_o   = out_v_q;
  assign row_sum_o = row_sum_q;

`ifndef SYNTH
  a_clear_at_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && last_q |=> acc_q == '0 && out_v_q)
    else $error("row end did not clear accumulator or raise result");

  a_hold_products: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && !consume |=> s1_v_q && $stable(pe_q) && $stable(po_q))
    else $error("stalled product stage lost its contents");
`endif

endmodule

`default_nettype wire

### rtl/q4_block_matvec_row_unit.sv
`default_nettype none

// q4 block matvec row unit: dot product of one row of 4-bit quantized weights
// with an activation vector, one packed weight byte per transaction.
// item_i: weight_byte (low nibble even column, high nibble odd), block_scale
//   (unsigned Q4.12), act_even / act_odd (signed Q4.12), end_of_row.
// result_o: row_sum, signed Q24.24, saturated; one transaction per row, sent
//   for the byte that carries end_of_row.
// throughput: one byte per cycle while no row end waits on a stalled receiver;
//   the front stage, the queue pop and the multiply and accumulate stages each
//   advance once per clock. Path to row_sum: front, queue, product, output.
// at reset the accumulator, the queue and all valid flags are cleared.
// a stalled receiver only blocks at a row end: the finished sum waits in the
//   output register while bytes of the next row keep flowing and
//   accumulating; the queue then fills and item_i.ready drops.
module q4_block_matvec_row_unit
  import q4mv_pkg::*;
#(
  parameter int unsigned ACT_WIDTH   = ACT_WIDTH_DEF,
  parameter int unsigned ACC_WIDTH   = ACC_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  q4mv_in_if.sink     item_i,
  q4mv_out_if.source  result_o
);

  // queue entry: scaled weights, end flag and both activations
  localparam int unsigned QW = $bits(wscale_t) + 2 * ACT_WIDTH;

  logic                        fr_valid, fr_ready;
  wscale_t                     fr_ws;
  logic signed [ACT_WIDTH-1:0] fr_ae, fr_ao;

  logic                        q_valid, q_ready;
  logic [QW-1:0]               q_data;
  wscale_t                     bk_ws;
  logic signed [ACT_WIDTH-1:0] bk_ae, bk_ao;

  // front: nibble decode and weight-times-scale
  q4mv_front #(
    .ACT_WIDTH (ACT_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (item_i.valid),
    .ready_o       (item_i.ready),
    .weight_byte_i (item_i.weight_byte),
    .block_scale_i (item_i.block_scale),
    .act_even_i    (item_i.act_even),
    .act_odd_i     (item_i.act_odd),
    .end_of_row_i  (item_i.end_of_row),
    .valid_o       (fr_valid),
    .ready_i       (fr_ready),
    .ws_o          (fr_ws),
    .act_even_o    (fr_ae),
    .act_odd_o     (fr_ao)
  );

  // decoupling queue between front and back
  q4mv_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .ready_o (fr_ready),
    .data_i  ({fr_ws, fr_ao, fr_ae}),
    .valid_o (q_valid),
    .ready_i (q_ready),
    .data_o  (q_data)
  );

  assign {bk_ws, bk_ao, bk_ae} = q_data;

  // back: activation multiply, saturating accumulate, result register
  q4mv_back #(
    .ACT_WIDTH (ACT_WIDTH),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .ready_o    (q_ready),
    .ws_i       (bk_ws),
    .act_even_i (bk_ae),
    .act_odd_i  (bk_ao),
    .valid_o    (result_o.valid),
    .ready_i    (result_o.ready),
    .row_sum_o  (result_o.row_sum)
  );

endmodule

`default_nettype wire
